@@ src/pid_controller_antiwindup_top_defines.svh @@
// Assertion macros for the PID controller top level.
// Needs clock and reset in scope where the macros are used.
`ifndef PID_CONTROLLER_ANTIWINDUP_TOP_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_TOP_DEFINES_SVH

// same-cycle implication
`define PID_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PID_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pid_pkg.sv @@
// Shared constants and types for the PID controller.
// No dependencies.
package pid_pkg;

   localparam int GAIN_W  = 32;
   localparam int SUM_W   = 32;
   localparam int LIMIT_W = 15;
   localparam int DRIVE_W = 16;
   localparam int TIME_W  = 16;
   localparam int OP_W    = 2;
   localparam int NUM_W   = 80;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   localparam logic [TIME_W-1:0] MS_PER_S = 16'd1000;

   localparam logic [OP_W-1:0] OP_PID  = 2'd0;
   localparam logic [OP_W-1:0] OP_PI   = 2'd1;
   localparam logic [OP_W-1:0] OP_PD   = 2'd2;
   localparam logic [OP_W-1:0] OP_RSVD = 2'd3;

   localparam logic [2:0] REG_KP_ROT   = 3'd0;
   localparam logic [2:0] REG_KI_ROT   = 3'd1;
   localparam logic [2:0] REG_KD_ROT   = 3'd2;
   localparam logic [2:0] REG_KP_TRANS = 3'd3;
   localparam logic [2:0] REG_KI_TRANS = 3'd4;
   localparam logic [2:0] REG_KD_TRANS = 3'd5;
   localparam logic [2:0] REG_LIMIT    = 3'd6;

   localparam logic [GAIN_W-1:0]  GAIN_ROT_RST   = 32'd65536;
   localparam logic [GAIN_W-1:0]  GAIN_TRANS_RST = 32'd0;
   localparam logic [LIMIT_W-1:0] LIMIT_RST      = 15'd1;

   typedef struct packed {
      logic signed [GAIN_W-1:0] kp_rot;
      logic signed [GAIN_W-1:0] ki_rot;
      logic signed [GAIN_W-1:0] kd_rot;
      logic signed [GAIN_W-1:0] kp_trans;
      logic signed [GAIN_W-1:0] ki_trans;
      logic signed [GAIN_W-1:0] kd_trans;
      logic [LIMIT_W-1:0]       drive_limit;
   } pid_csr_type;

   typedef struct packed {
      logic load;
      logic pmul;
      logic imul;
      logic ilo;
      logic ihi;
      logic idiv_go;
      logic icap;
      logic dmul;
      logic dscale;
      logic ddiv_go;
      logic dcap;
      logic finish;
   } pid_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            el_zero;
      logic            div_done;
      logic            out_free;
   } pid_sts_type;

endpackage

@@ src/pid_req_if.sv @@
// Request channel: one error sample per beat.
// Depends on pid_pkg.
interface pid_req_if import pid_pkg::*; #(parameter int ERROR_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic [OP_W-1:0]               op;
   logic                          gain_set;
   logic signed [ERROR_WIDTH-1:0] error_in;
   logic [TIME_W-1:0]             elapsed_ms;
   logic [LIMIT_W-1:0]            pi_limit;

   modport source (output valid, op, gain_set, error_in, elapsed_ms, pi_limit, input ready);
   modport sink (input valid, op, gain_set, error_in, elapsed_ms, pi_limit, output ready);
endinterface

@@ src/pid_rsp_if.sv @@
// Response channel: one controller output per beat.
// Depends on pid_pkg.
interface pid_rsp_if import pid_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      integral_clamped;
   logic                      output_clamped;
   logic                      no_time;

   modport source (output valid, drive, integral_clamped, output_clamped, no_time,
                   input ready);
   modport sink (input valid, drive, integral_clamped, output_clamped, no_time,
                 output ready);
endinterface

@@ src/pid_controller_antiwindup_top.sv @@
// PID controller with integral clamp. One request is worked on at a time.
// PID does both divisions, PI the integral one, PD the derivative one, reserved op or zero
// elapsed neither. Each runs start, 24 two-bit quotient steps, done; saturating: start, done.
// req ready returns the cycle after the result loads; a result still waiting holds that load.
// Reset is synchronous: clears error sum and previous error, loads gain and limit defaults.
// Depends on pid_pkg, pid_req_if, pid_rsp_if, pid_ctrl, pid_dp.
`include "pid_controller_antiwindup_top_defines.svh"
module pid_controller_antiwindup_top import pid_pkg::*; #(
   parameter int ERROR_WIDTH    = 16,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   pid_req_if.sink           req_bus,
   pid_rsp_if.source         rsp_bus,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);
   pid_csr_type csr_ff, csr_in;
   pid_cmd_type cmd;
   pid_sts_type sts;
   logic        csr_wr;
   logic [2:0]  csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[4:2];

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_KP_ROT:   csr_in.kp_rot      = pwdata;
            REG_KI_ROT:   csr_in.ki_rot      = pwdata;
            REG_KD_ROT:   csr_in.kd_rot      = pwdata;
            REG_KP_TRANS: csr_in.kp_trans    = pwdata;
            REG_KI_TRANS: csr_in.ki_trans    = pwdata;
            REG_KD_TRANS: csr_in.kd_trans    = pwdata;
            REG_LIMIT:    csr_in.drive_limit = pwdata[LIMIT_W-1:0];
            default:      csr_in = csr_ff;
         endcase
      end
      case (csr_idx)
         REG_KP_ROT:   prdata = csr_ff.kp_rot;
         REG_KI_ROT:   prdata = csr_ff.ki_rot;
         REG_KD_ROT:   prdata = csr_ff.kd_rot;
         REG_KP_TRANS: prdata = csr_ff.kp_trans;
         REG_KI_TRANS: prdata = csr_ff.ki_trans;
         REG_KD_TRANS: prdata = csr_ff.kd_trans;
         REG_LIMIT:    prdata = DATA_W'(csr_ff.drive_limit);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.kp_rot      <= GAIN_ROT_RST;
         csr_ff.ki_rot      <= GAIN_ROT_RST;
         csr_ff.kd_rot      <= GAIN_ROT_RST;
         csr_ff.kp_trans    <= GAIN_TRANS_RST;
         csr_ff.ki_trans    <= GAIN_TRANS_RST;
         csr_ff.kd_trans    <= GAIN_TRANS_RST;
         csr_ff.drive_limit <= LIMIT_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   pid_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_bus.valid),
      .req_ready(req_bus.ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   pid_dp #(.ERROR_WIDTH(ERROR_WIDTH), .GAIN_FRAC_BITS(GAIN_FRAC_BITS)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .csr             (csr_ff),
      .op              (req_bus.op),
      .gain_set        (req_bus.gain_set),
      .error_in        (req_bus.error_in),
      .elapsed_ms      (req_bus.elapsed_ms),
      .pi_limit        (req_bus.pi_limit),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .drive           (rsp_bus.drive),
      .integral_clamped(rsp_bus.integral_clamped),
      .output_clamped  (rsp_bus.output_clamped),
      .no_time         (rsp_bus.no_time)
   );

   `PID_ASSERT_NEXT(a_busy_after_beat, req_bus.valid && req_bus.ready, !req_bus.ready, "ready after req beat")
   `PID_ASSERT_NEXT(a_limit_write, csr_wr && csr_idx == REG_LIMIT, csr_ff.drive_limit == $past(pwdata[LIMIT_W-1:0]), "limit write lost")
   `PID_ASSERT_NOW(a_drive_range, rsp_bus.valid, rsp_bus.drive != 16'sh8000, "drive out of range")
endmodule

@@ src/pid_div.sv @@
// Radix-4 restoring divider, two quotient bits per cycle, saturation precheck.
// Depends on nothing outside this file.
module pid_div #(
   parameter int NUM_W = 80,
   parameter int QUO_W = 48
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [15:0]      den,
   output logic             done,
   output logic             sat,
   output logic [QUO_W-1:0] quot
);
   localparam int STEPS = QUO_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int HI_W  = NUM_W - QUO_W;

   logic [15:0]      rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [15:0]      den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic             sat_ff, sat_in;

   logic [HI_W-1:0] hi;
   logic            hi_ge;
   logic [16:0]     t1, t2, r1, r2;
   logic            ge1, ge2;

   always_comb begin
      hi    = num[NUM_W-1:QUO_W];
      hi_ge = hi >= HI_W'(den);
      t1    = {rem_ff, quo_ff[QUO_W-1]};
      ge1   = t1 >= {1'b0, den_ff};
      r1    = ge1 ? t1 - {1'b0, den_ff} : t1;
      t2    = {r1[15:0], quo_ff[QUO_W-2]};
      ge2   = t2 >= {1'b0, den_ff};
      r2    = ge2 ? t2 - {1'b0, den_ff} : t2;

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      sat_in  = sat_ff;
      done_in = 1'b0;
      if (start) begin
         den_in = den;
         if (hi_ge) begin
            sat_in  = 1'b1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            sat_in  = 1'b0;
            rem_in  = hi[15:0];
            quo_in  = num[QUO_W-1:0];
            cnt_in  = CNT_W'(STEPS);
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in = r2[15:0];
         quo_in = {quo_ff[QUO_W-3:0], ge1, ge2};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      sat_ff <= sat_in;
   end

   assign done = done_ff;
   assign sat  = sat_ff;
   assign quot = quo_ff;
endmodule

@@ src/pid_ctrl.sv @@
// Sequencer for the PID datapath: issues one command per step.
// Depends on pid_pkg.
module pid_ctrl import pid_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  pid_sts_type sts,
   output pid_cmd_type cmd
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PMUL   = 4'd1;
   localparam logic [3:0] S_IMUL   = 4'd2;
   localparam logic [3:0] S_ILO    = 4'd3;
   localparam logic [3:0] S_IHI    = 4'd4;
   localparam logic [3:0] S_IGO    = 4'd5;
   localparam logic [3:0] S_IWAIT  = 4'd6;
   localparam logic [3:0] S_DMUL   = 4'd7;
   localparam logic [3:0] S_DSCALE = 4'd8;
   localparam logic [3:0] S_DGO    = 4'd9;
   localparam logic [3:0] S_DWAIT  = 4'd10;
   localparam logic [3:0] S_FIN    = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PMUL;
            end
         end
         S_PMUL: begin
            cmd.pmul = 1'b1;
            if (sts.op == OP_RSVD || sts.el_zero) state_in = S_FIN;
            else if (sts.op == OP_PD) state_in = S_DMUL;
            else state_in = S_IMUL;
         end
         S_IMUL: begin
            cmd.imul = 1'b1;
            state_in = S_ILO;
         end
         S_ILO: begin
            cmd.ilo  = 1'b1;
            state_in = S_IHI;
         end
         S_IHI: begin
            cmd.ihi  = 1'b1;
            state_in = S_IGO;
         end
         S_IGO: begin
            cmd.idiv_go = 1'b1;
            state_in    = S_IWAIT;
         end
         S_IWAIT: begin
            if (sts.div_done) begin
               cmd.icap = 1'b1;
               state_in = (sts.op == OP_PI) ? S_FIN : S_DMUL;
            end
         end
         S_DMUL: begin
            cmd.dmul = 1'b1;
            state_in = S_DSCALE;
         end
         S_DSCALE: begin
            cmd.dscale = 1'b1;
            state_in   = S_DGO;
         end
         S_DGO: begin
            cmd.ddiv_go = 1'b1;
            state_in    = S_DWAIT;
         end
         S_DWAIT: begin
            if (sts.div_done) begin
               cmd.dcap = 1'b1;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
endmodule

@@ src/pid_dp.sv @@
// PID datapath: shared multiplier, divider, term assembly, clamps and state.
// Depends on pid_pkg and pid_div.
module pid_dp import pid_pkg::*; #(
   parameter int ERROR_WIDTH    = 16,
   parameter int GAIN_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pid_cmd_type                   cmd,
   output pid_sts_type                   sts,
   input  pid_csr_type                   csr,
   input  logic [OP_W-1:0]               op,
   input  logic                          gain_set,
   input  logic signed [ERROR_WIDTH-1:0] error_in,
   input  logic [TIME_W-1:0]             elapsed_ms,
   input  logic [LIMIT_W-1:0]            pi_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [DRIVE_W-1:0]     drive,
   output logic                          integral_clamped,
   output logic                          output_clamped,
   output logic                          no_time
);
   localparam int EW     = ERROR_WIDTH;
   localparam int DIFF_W = EW + 1;
   localparam int CAP_W  = 31 + GAIN_FRAC_BITS;
   localparam int QUO_W  = ((CAP_W + 2) / 2) * 2;
   localparam int TOT_W  = CAP_W + 3;
   localparam int DMAG_W = TOT_W - GAIN_FRAC_BITS;
   localparam logic [CAP_W-1:0] CAP = {CAP_W{1'b1}};

   logic [OP_W-1:0]          op_ff, op_in;
   logic signed [EW-1:0]     e_ff, e_in;
   logic [TIME_W-1:0]        el_ff, el_in;
   logic [LIMIT_W-1:0]       lim_ff, lim_in;
   logic signed [GAIN_W-1:0] kp_ff, kp_in, ki_ff, ki_in, kd_ff, kd_in;
   logic [CAP_W-1:0]         p_ff, p_in, i_ff, i_in, d_ff, d_in;
   logic [63:0]              m_ff, m_in;
   logic [NUM_W-1:0]         x_ff, x_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [EW-1:0]     prev_ff, prev_in;
   logic                     rv_ff, rv_in;
   logic [DRIVE_W-1:0]       drive_ff, drive_in;
   logic                     icl_ff, icl_in, ocl_ff, ocl_in, nt_ff, nt_in;

   logic [GAIN_W-1:0]        kp_mag, ki_mag, kd_mag, sum_mag;
   logic [EW-1:0]            e_mag;
   logic signed [DIFF_W-1:0] diff;
   logic [DIFF_W-1:0]        diff_mag;
   logic [31:0]              mul_a;
   logic [32:0]              mul_b;
   logic [64:0]              prod;
   logic                     div_start, div_done, div_sat;
   logic [QUO_W-1:0]         quot;
   logic [CAP_W-1:0]         quo_term;
   logic [TIME_W-1:0]        div_den;

   logic signed [TOT_W-1:0]  p_t, i_t, d_t, limq_t, i_use, total;
   logic [TOT_W-1:0]         tot_mag;
   logic [DMAG_W-1:0]        dmag;
   logic [LIMIT_W-1:0]       dclamp;
   logic [DRIVE_W-1:0]       dwide;
   logic                     icl, ocl, e_nonneg, e_nonpos, out_free;
   logic signed [SUM_W:0]    s_wide;
   logic signed [SUM_W-1:0]  s_sat;

   always_comb begin
      kp_mag   = kp_ff[GAIN_W-1] ? GAIN_W'(-kp_ff) : GAIN_W'(kp_ff);
      ki_mag   = ki_ff[GAIN_W-1] ? GAIN_W'(-ki_ff) : GAIN_W'(ki_ff);
      kd_mag   = kd_ff[GAIN_W-1] ? GAIN_W'(-kd_ff) : GAIN_W'(kd_ff);
      sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      e_mag    = e_ff[EW-1] ? EW'(-e_ff) : EW'(e_ff);
      diff     = DIFF_W'(e_ff) - DIFF_W'(prev_ff);
      diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

      mul_a = '0;
      mul_b = '0;
      if (cmd.pmul) begin
         mul_a = kp_mag;
         mul_b = 33'(e_mag);
      end else if (cmd.imul) begin
         mul_a = sum_mag;
         mul_b = 33'(ki_mag);
      end else if (cmd.ilo) begin
         mul_a = m_ff[31:0];
         mul_b = 33'(el_ff);
      end else if (cmd.ihi) begin
         mul_a = m_ff[63:32];
         mul_b = 33'(el_ff);
      end else if (cmd.dmul) begin
         mul_a = kd_mag;
         mul_b = 33'(diff_mag);
      end
      prod = {33'd0, mul_a} * {32'd0, mul_b};
   end

   assign div_start = cmd.idiv_go | cmd.ddiv_go;
   assign div_den   = cmd.idiv_go ? MS_PER_S : el_ff;

   pid_div #(.NUM_W(NUM_W), .QUO_W(QUO_W)) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  (x_ff),
      .den  (div_den),
      .done (div_done),
      .sat  (div_sat),
      .quot (quot)
   );

   assign quo_term = (div_sat || quot[QUO_W-1:CAP_W] != '0) ? CAP : quot[CAP_W-1:0];

   // term assembly, clamps and saturated error sum for the finishing step
   always_comb begin
      p_t = (kp_ff[GAIN_W-1] != e_ff[EW-1]) ? -$signed(TOT_W'(p_ff)) : $signed(TOT_W'(p_ff));
      i_t = (sum_ff[SUM_W-1] != ki_ff[GAIN_W-1]) ? -$signed(TOT_W'(i_ff))
                                                 : $signed(TOT_W'(i_ff));
      d_t = (diff[DIFF_W-1] != kd_ff[GAIN_W-1]) ? -$signed(TOT_W'(d_ff))
                                                : $signed(TOT_W'(d_ff));
      limq_t   = $signed(TOT_W'(lim_ff)) <<< GAIN_FRAC_BITS;
      e_nonneg = !e_ff[EW-1];
      e_nonpos = e_ff[EW-1] || (e_ff == '0);
      icl      = 1'b0;
      i_use    = i_t;
      if (op_ff == OP_PD) begin
         i_use = '0;
      end else if (i_t >= limq_t && e_nonneg) begin
         i_use = limq_t;
         icl   = 1'b1;
      end else if (i_t <= -limq_t && e_nonpos) begin
         i_use = -limq_t;
         icl   = 1'b1;
      end
      total   = p_t + i_use + d_t;
      tot_mag = total[TOT_W-1] ? TOT_W'(-total) : TOT_W'(total);
      dmag    = tot_mag[TOT_W-1:GAIN_FRAC_BITS];
      ocl     = dmag > DMAG_W'(lim_ff);
      dclamp  = ocl ? lim_ff : dmag[LIMIT_W-1:0];
      dwide   = {1'b0, dclamp};

      s_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(e_ff);
      if (s_wide[SUM_W] != s_wide[SUM_W-1])
         s_sat = s_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      else
         s_sat = s_wide[SUM_W-1:0];
   end

   assign out_free = !rv_ff || rsp_ready;

   always_comb begin
      op_in    = op_ff;
      e_in     = e_ff;
      el_in    = el_ff;
      lim_in   = lim_ff;
      kp_in    = kp_ff;
      ki_in    = ki_ff;
      kd_in    = kd_ff;
      p_in     = p_ff;
      i_in     = i_ff;
      d_in     = d_ff;
      m_in     = m_ff;
      x_in     = x_ff;
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      drive_in = drive_ff;
      icl_in   = icl_ff;
      ocl_in   = ocl_ff;
      nt_in    = nt_ff;
      rv_in    = rv_ff && !rsp_ready;
      if (cmd.load) begin
         op_in  = op;
         e_in   = error_in;
         el_in  = elapsed_ms;
         lim_in = (op == OP_PI) ? pi_limit : csr.drive_limit;
         kp_in  = gain_set ? csr.kp_trans : csr.kp_rot;
         ki_in  = gain_set ? csr.ki_trans : csr.ki_rot;
         kd_in  = gain_set ? csr.kd_trans : csr.kd_rot;
         i_in   = '0;
         d_in   = '0;
      end
      if (cmd.pmul) p_in = (prod[64:CAP_W] != '0) ? CAP : prod[CAP_W-1:0];
      if (cmd.imul || cmd.dmul) m_in = prod[63:0];
      if (cmd.ilo) x_in = NUM_W'(prod);
      if (cmd.ihi) x_in = x_ff + NUM_W'({prod, 32'd0});
      if (cmd.dscale) x_in = (NUM_W'(m_ff) << 10) - (NUM_W'(m_ff) << 4) - (NUM_W'(m_ff) << 3);
      if (cmd.icap) i_in = quo_term;
      if (cmd.dcap) d_in = quo_term;
      if (cmd.finish) begin
         rv_in = 1'b1;
         if (op_ff == OP_RSVD) begin
            drive_in = '0;
            icl_in   = 1'b0;
            ocl_in   = 1'b0;
            nt_in    = 1'b0;
         end else begin
            drive_in = total[TOT_W-1] ? DRIVE_W'(-dwide) : dwide;
            icl_in   = icl;
            ocl_in   = ocl;
            nt_in    = (op_ff != OP_PI) && (el_ff == '0);
            prev_in  = e_ff;
            if (op_ff != OP_PD && !icl) sum_in = s_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         prev_ff <= '0;
         rv_ff   <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         prev_ff <= prev_in;
         rv_ff   <= rv_in;
      end
      op_ff    <= op_in;
      e_ff     <= e_in;
      el_ff    <= el_in;
      lim_ff   <= lim_in;
      kp_ff    <= kp_in;
      ki_ff    <= ki_in;
      kd_ff    <= kd_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      d_ff     <= d_in;
      m_ff     <= m_in;
      x_ff     <= x_in;
      drive_ff <= drive_in;
      icl_ff   <= icl_in;
      ocl_ff   <= ocl_in;
      nt_ff    <= nt_in;
   end

   assign sts.op       = op_ff;
   assign sts.el_zero  = (el_ff == '0);
   assign sts.div_done = div_done;
   assign sts.out_free = out_free;

   assign rsp_valid        = rv_ff;
   assign drive            = $signed(drive_ff);
   assign integral_clamped = icl_ff;
   assign output_clamped   = ocl_ff;
   assign no_time          = nt_ff;
endmodule
